/* rtl/tccc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tccc_pkg: shared definitions for the timed cooling cycle controller
// Field widths, register indexes, process and reason codes, result record.
// ----------------------------------------------------------------------------
package tccc_pkg;

    // width of the internal time base; the input time is taken modulo 2^TIME_BITS
    localparam int TIME_BITS = 32;

    // fixed field widths
    localparam int NOW_W     = 32;
    localparam int TEMP_W    = 12;
    localparam int WATER_W   = 7;
    localparam int SEC_W     = 16;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 3;
    localparam int PROC_W    = 3;
    localparam int RSN_W     = 2;

    localparam int MS_PER_S  = 1000;
    // seconds times 1000 fits in SEC_W + 10 bits
    localparam int DUR_W     = SEC_W + 10;
    localparam int CMP_W     = (TIME_BITS > DUR_W) ? TIME_BITS : DUR_W;

    typedef logic [TIME_BITS-1:0] time_t;
    typedef logic [DUR_W-1:0]     dur_t;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TEMP_LIMIT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WATER_MIN  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WATER_SEC  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LOCK_SEC   = 3'd3;

    // configuration reset values
    localparam logic signed [TEMP_W-1:0] TEMP_LIMIT_RST = 12'sd300;
    localparam logic [WATER_W-1:0]       WATER_MIN_RST  = 7'd20;
    localparam logic [SEC_W-1:0]         WATER_SEC_RST  = 16'd60;
    localparam logic [SEC_W-1:0]         LOCK_SEC_RST   = 16'd300;

    // process codes
    localparam logic [PROC_W-1:0] P_IDLE   = 3'd0;
    localparam logic [PROC_W-1:0] P_MANUAL = 3'd1;
    localparam logic [PROC_W-1:0] P_MAINT  = 3'd2;
    localparam logic [PROC_W-1:0] P_COOL   = 3'd3;
    localparam logic [PROC_W-1:0] P_LOCK   = 3'd4;

    // reason codes
    localparam logic [RSN_W-1:0] R_IDLE   = 2'd0;
    localparam logic [RSN_W-1:0] R_HOT    = 2'd1;
    localparam logic [RSN_W-1:0] R_CYCLE  = 2'd1;
    localparam logic [RSN_W-1:0] R_LOWW   = 2'd2;
    localparam logic [RSN_W-1:0] R_FMAINT = 2'd2;
    localparam logic [RSN_W-1:0] R_MAINT  = 2'd3;

    typedef struct packed {
        logic [PROC_W-1:0] process;
        logic              fan_on;
        logic              pump_on;
        logic              valve_on;
        logic [RSN_W-1:0]  fan_reason;
        logic [RSN_W-1:0]  pump_reason;
        logic [RSN_W-1:0]  valve_reason;
        logic              beep;
        logic              clear_manual;
        logic [NOW_W-1:0]  lockout_until_ms;
    } res_t;

    // seconds to milliseconds, a constant multiply
    function automatic dur_t sec_to_ms(input logic [SEC_W-1:0] sec);
        return DUR_W'(sec) * DUR_W'(MS_PER_S);
    endfunction

endpackage

/* rtl/timed_cooling_cycle_controller.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timed_cooling_cycle_controller
// Fan, pump and valve relay control with a timed cooling run and lockout.
// ----------------------------------------------------------------------------
//  channel  | handshake               | payload
//  ---------+-------------------------+--------------------------------------
//  in       | in_valid / in_stall     | now_ms, temperature_now, water_now,
//           |                         | manual_mode, maintenance
//  out      | out_valid / out_stall   | process, relay bits, reasons, beep,
//           |                         | clear_manual, lockout_until_ms
//  cfg      | cfg_wr_en               | cfg_index, cfg_data
//
//  one transaction per cycle sustained while out_stall is low; a result is
//  registered in the input register, then in the result register
//  controller state is updated as the input register moves into the result
//  register, one compare/subtract deep
//  reset clears the control state and loads the default register values
//  out_stall holds the result register and backs up to in_stall
// ----------------------------------------------------------------------------
module timed_cooling_cycle_controller (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // configuration
    input  logic                                 cfg_wr_en,
    input  logic [tccc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [tccc_pkg::CFG_W-1:0]           cfg_data,
    // input channel
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [tccc_pkg::NOW_W-1:0]           now_ms,
    input  logic signed [tccc_pkg::TEMP_W-1:0]   temperature_now,
    input  logic [tccc_pkg::WATER_W-1:0]         water_now,
    input  logic                                 manual_mode,
    input  logic                                 maintenance,
    // output channel
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [tccc_pkg::PROC_W-1:0]          process,
    output logic                                 fan_on,
    output logic                                 pump_on,
    output logic                                 valve_on,
    output logic [tccc_pkg::RSN_W-1:0]           fan_reason,
    output logic [tccc_pkg::RSN_W-1:0]           pump_reason,
    output logic [tccc_pkg::RSN_W-1:0]           valve_reason,
    output logic                                 beep,
    output logic                                 clear_manual,
    output logic [tccc_pkg::NOW_W-1:0]           lockout_until_ms
);
    import tccc_pkg::*;

    // configuration registers
    logic signed [TEMP_W-1:0] temp_limit_reg;
    logic [WATER_W-1:0]       water_min_reg;
    dur_t                     water_ms_reg;
    dur_t                     lock_ms_reg;

    // input register
    logic                     s1_valid_reg;
    time_t                    now_reg;
    logic signed [TEMP_W-1:0] temp_reg;
    logic [WATER_W-1:0]       water_reg;
    logic                     manual_reg;
    logic                     maint_reg;

    // controller state
    logic                     prev_manual_reg,   prev_manual_next;
    logic                     cooling_reg,       cooling_next;
    logic                     locked_reg,        locked_next;
    time_t                    cool_start_reg,    cool_start_next;
    time_t                    lock_start_reg,    lock_start_next;
    time_t                    lock_end_reg,      lock_end_next;
    logic                     fan_rel_reg,       fan_rel_next;
    logic                     pump_rel_reg,      pump_rel_next;
    logic                     valve_rel_reg,     valve_rel_next;
    logic [PROC_W-1:0]        proc_reg,          proc_next;
    logic [RSN_W-1:0]         fan_rsn_reg,       fan_rsn_next;
    logic [RSN_W-1:0]         pump_rsn_reg,      pump_rsn_next;
    logic [RSN_W-1:0]         valve_rsn_reg,     valve_rsn_next;
    logic                     beep_next;
    logic                     clr_next;

    // result register
    logic                     out_valid_reg;
    res_t                     res_reg;
    res_t                     res_next;

    logic                     out_ready;
    logic                     s1_fire;
    logic                     in_fire;
    logic                     hot;
    logic                     lock_done;
    logic                     cool_done;
    time_t                    lock_elapsed;
    time_t                    cool_elapsed;

    assign out_ready = !out_valid_reg || !out_stall;
    assign s1_fire   = s1_valid_reg && out_ready;
    assign in_stall  = s1_valid_reg && !out_ready;
    assign in_fire   = in_valid && !in_stall;

    // configuration writes, durations kept in milliseconds
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            temp_limit_reg <= TEMP_LIMIT_RST;
            water_min_reg  <= WATER_MIN_RST;
            water_ms_reg   <= sec_to_ms(WATER_SEC_RST);
            lock_ms_reg    <= sec_to_ms(LOCK_SEC_RST);
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_TEMP_LIMIT: temp_limit_reg <= $signed(cfg_data[TEMP_W-1:0]);
                CFG_WATER_MIN:  water_min_reg  <= cfg_data[WATER_W-1:0];
                CFG_WATER_SEC:  water_ms_reg   <= sec_to_ms(cfg_data[SEC_W-1:0]);
                CFG_LOCK_SEC:   lock_ms_reg    <= sec_to_ms(cfg_data[SEC_W-1:0]);
                default:        ;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_fire)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            now_reg    <= TIME_BITS'(now_ms);
            temp_reg   <= temperature_now;
            water_reg  <= water_now;
            manual_reg <= manual_mode;
            maint_reg  <= maintenance;
        end
    end

    // one evaluation step
    assign hot          = temp_reg >= temp_limit_reg;
    assign lock_elapsed = now_reg - lock_start_reg;
    assign lock_done    = CMP_W'(lock_elapsed) >= CMP_W'(lock_ms_reg);
    // a run that starts in this step has its start at now, so nothing elapsed
    assign cool_elapsed = cooling_reg ? (now_reg - cool_start_reg) : '0;
    assign cool_done    = CMP_W'(cool_elapsed) >= CMP_W'(water_ms_reg);

    always_comb
    begin
        prev_manual_next = manual_reg;
        cooling_next     = cooling_reg;
        locked_next      = locked_reg;
        cool_start_next  = cool_start_reg;
        lock_start_next  = lock_start_reg;
        lock_end_next    = lock_end_reg;
        fan_rel_next     = fan_rel_reg;
        pump_rel_next    = pump_rel_reg;
        valve_rel_next   = valve_rel_reg;
        proc_next        = proc_reg;
        fan_rsn_next     = fan_rsn_reg;
        pump_rsn_next    = pump_rsn_reg;
        valve_rsn_next   = valve_rsn_reg;
        beep_next        = 1'b0;
        clr_next         = 1'b0;

        // leaving manual: all relays off
        if (prev_manual_reg && !manual_reg)
        begin
            fan_rel_next   = 1'b0;
            pump_rel_next  = 1'b0;
            valve_rel_next = 1'b0;
            fan_rsn_next   = R_IDLE;
            pump_rsn_next  = R_IDLE;
            valve_rsn_next = R_IDLE;
            clr_next       = 1'b1;
            proc_next      = P_IDLE;
        end

        if (manual_reg)
        begin
            proc_next = P_MANUAL;
        end
        else if (maint_reg)
        begin
            proc_next      = P_MAINT;
            fan_rel_next   = 1'b0;
            pump_rel_next  = 1'b0;
            valve_rel_next = 1'b0;
            fan_rsn_next   = R_FMAINT;
            pump_rsn_next  = R_MAINT;
            valve_rsn_next = R_MAINT;
        end
        else
        begin
            fan_rel_next = hot;
            fan_rsn_next = hot ? R_HOT : R_IDLE;

            if (locked_reg)
            begin
                if (lock_done)
                begin
                    locked_next = 1'b0;
                    proc_next   = P_IDLE;
                end
            end
            else
            begin
                if (!cooling_reg && hot && (water_reg > water_min_reg))
                begin
                    cooling_next    = 1'b1;
                    cool_start_next = now_reg;
                    proc_next       = P_COOL;
                    beep_next       = 1'b1;
                    pump_rel_next   = 1'b1;
                    pump_rsn_next   = R_CYCLE;
                    valve_rel_next  = 1'b1;
                    valve_rsn_next  = R_CYCLE;
                end

                // cool_elapsed sees a run that started in this same step
                if (cooling_next && cool_done)
                begin
                    valve_rel_next  = 1'b0;
                    valve_rsn_next  = R_IDLE;
                    pump_rel_next   = 1'b0;
                    pump_rsn_next   = R_IDLE;
                    cooling_next    = 1'b0;
                    locked_next     = 1'b1;
                    lock_start_next = now_reg;
                    lock_end_next   = now_reg + TIME_BITS'(lock_ms_reg);
                    proc_next       = P_LOCK;
                end

                if (water_reg <= water_min_reg)
                begin
                    pump_rel_next  = 1'b0;
                    pump_rsn_next  = R_LOWW;
                    valve_rel_next = 1'b0;
                    valve_rsn_next = R_LOWW;
                end
            end
        end
    end

    always_comb
    begin
        res_next.process          = proc_next;
        res_next.fan_on           = fan_rel_next;
        res_next.pump_on          = pump_rel_next;
        res_next.valve_on         = valve_rel_next;
        res_next.fan_reason       = fan_rsn_next;
        res_next.pump_reason      = pump_rsn_next;
        res_next.valve_reason     = valve_rsn_next;
        res_next.beep             = beep_next;
        res_next.clear_manual     = clr_next;
        res_next.lockout_until_ms = NOW_W'(lock_end_next);
    end

    // controller state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_manual_reg <= 1'b0;
            cooling_reg     <= 1'b0;
            locked_reg      <= 1'b0;
            cool_start_reg  <= '0;
            lock_start_reg  <= '0;
            lock_end_reg    <= '0;
            fan_rel_reg     <= 1'b0;
            pump_rel_reg    <= 1'b0;
            valve_rel_reg   <= 1'b0;
            proc_reg        <= P_IDLE;
            fan_rsn_reg     <= R_IDLE;
            pump_rsn_reg    <= R_IDLE;
            valve_rsn_reg   <= R_IDLE;
        end
        else if (s1_fire)
        begin
            prev_manual_reg <= prev_manual_next;
            cooling_reg     <= cooling_next;
            locked_reg      <= locked_next;
            cool_start_reg  <= cool_start_next;
            lock_start_reg  <= lock_start_next;
            lock_end_reg    <= lock_end_next;
            fan_rel_reg     <= fan_rel_next;
            pump_rel_reg    <= pump_rel_next;
            valve_rel_reg   <= valve_rel_next;
            proc_reg        <= proc_next;
            fan_rsn_reg     <= fan_rsn_next;
            pump_rsn_reg    <= pump_rsn_next;
            valve_rsn_reg   <= valve_rsn_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid        = out_valid_reg;
    assign process          = res_reg.process;
    assign fan_on           = res_reg.fan_on;
    assign pump_on          = res_reg.pump_on;
    assign valve_on         = res_reg.valve_on;
    assign fan_reason       = res_reg.fan_reason;
    assign pump_reason      = res_reg.pump_reason;
    assign valve_reason     = res_reg.valve_reason;
    assign beep             = res_reg.beep;
    assign clear_manual     = res_reg.clear_manual;
    assign lockout_until_ms = res_reg.lockout_until_ms;

    // a run and its lockout never overlap
    a_run_lock_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(cooling_reg && locked_reg))
        else $error("cooling run and lockout both active");

    // pump and valve always switch together
    a_pump_valve: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (res_reg.pump_on == res_reg.valve_on))
        else $error("pump and valve relays disagree");

    // a beep only comes with a run start or its immediate end
    a_beep_proc: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && res_reg.beep) |->
            (res_reg.process == P_COOL || res_reg.process == P_LOCK))
        else $error("beep without a cooling start");

    // high temperature reason means the fan runs
    a_fan_hot: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && res_reg.fan_reason == R_HOT) |-> res_reg.fan_on)
        else $error("fan reason hot with fan off");

    // a stalled result is not overwritten
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> $stable(res_reg))
        else $error("result changed under stall");

endmodule
